// ----- rtl/fir_pkg.sv -----
// shared types and constants for the streaming fir filter
// no dependencies; used by fir_mac, fir_filter_stream_unit and the bench
`default_nettype none

package fir_pkg;

    localparam int DEFAULT_MAX_TAPS = 64;
    localparam int DATA_W           = 16;
    localparam int TAP_CNT_W        = 7;
    localparam int COEF_IDX_W       = 6;
    localparam int FRAC_W           = 15;

    localparam logic [TAP_CNT_W-1:0] TAP_CNT_RESET = 7'd64;

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic acc_clear;
        logic issue;
    } mac_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/fir_filter_stream_unit.sv -----
// Direct-form FIR filter over a stream of Q1.15 samples.
// Input channel (in_valid/in_ready) carries words that either filter one
// sample (operation 0) or load one coefficient (operation 1). Each filter
// word yields one output word (sample_out, saturated) on out_valid/out_ready.
// Coefficient loads give no output.
// Samples and coefficients live in two synchronous RAMs of MAX_TAPS entries;
// one shared multiplier walks the taps, one tap per cycle.
// A filter word walks its taps in ST_RUN, where taps is tap_count clamped
// to 1..MAX_TAPS, then drains and waits in ST_DONE; in_ready is high only
// between words, so no word is taken before the last one leaves ST_DONE.
// After reset both RAMs are cleared in a pass over all MAX_TAPS entries
// during which in_ready stays low; cfg writes are taken at any time.
// Result is held in an output register: the next word can be accepted while
// it waits. If the receiver stalls, a finished sum waits in the sequencer
// until the output register frees up.
// tap_count is written through cfg_wr_en/cfg_wr_data and resets to 64.
// depends on fir_pkg, fir_ram, fir_mac
`default_nettype none

module fir_filter_stream_unit #(
    parameter int MAX_TAPS = fir_pkg::DEFAULT_MAX_TAPS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic        [fir_pkg::TAP_CNT_W-1:0]  cfg_wr_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  operation,
    input  wire logic signed [fir_pkg::DATA_W-1:0]     sample_in,
    input  wire logic        [fir_pkg::COEF_IDX_W-1:0] coef_index,
    input  wire logic signed [fir_pkg::DATA_W-1:0]     coef_value,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [fir_pkg::DATA_W-1:0]          sample_out,
    output logic                                       saturated
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int ACC_W = 2 * fir_pkg::DATA_W + AW;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

    fir_pkg::state_t state_reg, state_next;

    logic [fir_pkg::TAP_CNT_W-1:0] tap_count_reg;
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [AW-1:0] taps_last;

    logic                              out_valid_reg, out_valid_next;
    logic signed [fir_pkg::DATA_W-1:0] sample_out_reg;
    logic                              saturated_reg;
    logic                              out_load;

    logic                              in_acc;
    logic                              coef_idx_ok;
    logic                              dl_wr_en, cf_wr_en;
    logic [AW-1:0]                     dl_wr_addr, cf_wr_addr;
    logic signed [fir_pkg::DATA_W-1:0] dl_wr_data, cf_wr_data;
    logic signed [fir_pkg::DATA_W-1:0] dl_rd_data, cf_rd_data;
    logic signed [fir_pkg::DATA_W-1:0] mac_y;
    logic                              mac_sat;
    logic                              mac_busy;
    fir_pkg::mac_ctrl_t                mac_ctrl;

    assign in_acc      = in_valid & in_ready;
    assign coef_idx_ok = int'(coef_index) < MAX_TAPS;

    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps_last = '0;
        end
        else if (int'(tap_count_reg) > MAX_TAPS)
        begin
            taps_last = LAST_ADDR;
        end
        else
        begin
            taps_last = AW'(tap_count_reg - 7'd1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fir_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = fir_pkg::ST_IDLE;
                end
            end
            fir_pkg::ST_IDLE:
            begin
                if (in_valid && operation == fir_pkg::OP_FILTER)
                begin
                    state_next = fir_pkg::ST_RUN;
                end
            end
            fir_pkg::ST_RUN:
            begin
                if (k_reg == taps_last)
                begin
                    state_next = fir_pkg::ST_DRAIN;
                end
            end
            fir_pkg::ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = fir_pkg::ST_DONE;
                end
            end
            fir_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = fir_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fir_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        in_ready           = 1'b0;
        mac_ctrl.acc_clear = 1'b0;
        mac_ctrl.issue     = 1'b0;
        out_load           = 1'b0;
        dl_wr_en           = 1'b0;
        dl_wr_addr         = wp_reg;
        dl_wr_data         = sample_in;
        cf_wr_en           = 1'b0;
        cf_wr_addr         = AW'(coef_index);
        cf_wr_data         = coef_value;
        wp_next            = wp_reg;
        k_next             = k_reg;
        pos_next           = pos_reg;
        clr_addr_next      = clr_addr_reg;
        unique case (state_reg)
            fir_pkg::ST_CLEAR:
            begin
                dl_wr_en      = 1'b1;
                dl_wr_addr    = clr_addr_reg;
                dl_wr_data    = '0;
                cf_wr_en      = 1'b1;
                cf_wr_addr    = clr_addr_reg;
                cf_wr_data    = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            fir_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && operation == fir_pkg::OP_LOAD)
                begin
                    cf_wr_en = coef_idx_ok;
                end
                else if (in_valid)
                begin
                    dl_wr_en           = 1'b1;
                    mac_ctrl.acc_clear = 1'b1;
                    k_next             = '0;
                    pos_next           = wp_reg;
                    wp_next            = (wp_reg == LAST_ADDR) ? '0 : wp_reg + AW'(1);
                end
            end
            fir_pkg::ST_RUN:
            begin
                mac_ctrl.issue = 1'b1;
                k_next         = k_reg + AW'(1);
                pos_next       = (pos_reg == '0) ? LAST_ADDR : pos_reg - AW'(1);
            end
            fir_pkg::ST_DRAIN:
            begin
            end
            fir_pkg::ST_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fir_pkg::ST_CLEAR;
            tap_count_reg <= fir_pkg::TAP_CNT_RESET;
            wp_reg        <= '0;
            k_reg         <= '0;
            pos_reg       <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            k_reg         <= k_next;
            pos_reg       <= pos_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                tap_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            sample_out_reg <= mac_y;
            saturated_reg  <= mac_sat;
        end
    end

    // sample history
    fir_ram #(
        .WIDTH (fir_pkg::DATA_W),
        .DEPTH (MAX_TAPS)
    ) u_delay_ram (
        .clk     (clk),
        .wr_en   (dl_wr_en),
        .wr_addr (dl_wr_addr),
        .wr_data (dl_wr_data),
        .rd_en   (mac_ctrl.issue),
        .rd_addr (pos_reg),
        .rd_data (dl_rd_data)
    );

    // coefficients
    fir_ram #(
        .WIDTH (fir_pkg::DATA_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (cf_wr_en),
        .wr_addr (cf_wr_addr),
        .wr_data (cf_wr_data),
        .rd_en   (mac_ctrl.issue),
        .rd_addr (k_reg),
        .rd_data (cf_rd_data)
    );

    fir_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .coef  (cf_rd_data),
        .smp   (dl_rd_data),
        .busy  (mac_busy),
        .y     (mac_y),
        .sat   (mac_sat)
    );

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign saturated  = saturated_reg;

endmodule

`default_nettype wire

// ----- rtl/fir_ram.sv -----
// generic single-write, single-read synchronous ram with registered read
// no dependencies
`default_nettype none

module fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fir_mac.sv -----
// multiply-accumulate datapath with rounding and saturation to q1.15
// depends on fir_pkg
`default_nettype none

module fir_mac #(
    parameter int ACC_W = 38
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire fir_pkg::mac_ctrl_t                ctrl,
    input  wire logic signed [fir_pkg::DATA_W-1:0] coef,
    input  wire logic signed [fir_pkg::DATA_W-1:0] smp,
    output logic                                   busy,
    output logic signed [fir_pkg::DATA_W-1:0]      y,
    output logic                                   sat
);

    localparam int PROD_W = 2 * fir_pkg::DATA_W;
    localparam int SUM_W  = ACC_W + 1;

    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) <<< (fir_pkg::FRAC_W - 1);
    localparam logic signed [SUM_W-1:0] Y_MAX = SUM_W'((1 << (fir_pkg::DATA_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] Y_MIN = -(SUM_W'(1) <<< (fir_pkg::DATA_W - 1));

    logic                     rd_vld_reg;
    logic                     prod_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  y_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= ctrl.issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.acc_clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            prod_reg <= coef * smp;
        end
        acc_reg <= acc_next;
    end

    assign busy   = rd_vld_reg | prod_vld_reg;
    assign sum    = SUM_W'(acc_reg) + ROUND_BIAS;
    assign y_full = sum >>> fir_pkg::FRAC_W;

    always_comb
    begin
        sat = 1'b0;
        y   = y_full[fir_pkg::DATA_W-1:0];
        if (y_full > Y_MAX)
        begin
            sat = 1'b1;
            y   = Y_MAX[fir_pkg::DATA_W-1:0];
        end
        else if (y_full < Y_MIN)
        begin
            sat = 1'b1;
            y   = Y_MIN[fir_pkg::DATA_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- bench/fir_stream_checker.sv -----
// checker for the streaming fir filter: watches the cfg, input and output channels,
// predicts every filtered word from its own copy of taps, history and coefficients
// depends on fir_pkg
module fir_stream_checker #(
    parameter int MAX_TAPS = fir_pkg::DEFAULT_MAX_TAPS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic        [fir_pkg::TAP_CNT_W-1:0]  cfg_wr_data,
    input  wire logic                                  in_valid,
    input  wire logic                                  in_ready,
    input  wire logic                                  operation,
    input  wire logic signed [fir_pkg::DATA_W-1:0]     sample_in,
    input  wire logic        [fir_pkg::COEF_IDX_W-1:0] coef_index,
    input  wire logic signed [fir_pkg::DATA_W-1:0]     coef_value,
    input  wire logic                                  out_valid,
    input  wire logic                                  out_ready,
    input  wire logic signed [fir_pkg::DATA_W-1:0]     sample_out,
    input  wire logic                                  saturated,
    output int                                         mismatch_count,
    output int                                         pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAMPLE_MAX = (longint'(1) <<< (fir_pkg::DATA_W - 1)) - 1;
    localparam longint SAMPLE_MIN = -(longint'(1) <<< (fir_pkg::DATA_W - 1));
    localparam longint ROUND_HALF = longint'(1) <<< (fir_pkg::FRAC_W - 1);

    typedef struct packed {
        logic signed [fir_pkg::DATA_W-1:0] sample;
        logic                              sat;
    } fir_word_t;

    logic signed [fir_pkg::DATA_W-1:0] sample_hist [MAX_TAPS];
    logic signed [fir_pkg::DATA_W-1:0] coef_mem [MAX_TAPS];
    int                                hist_head;
    logic [fir_pkg::TAP_CNT_W-1:0]     tap_setting;
    fir_word_t                         expected_words [$];
    int                                errs;

    function automatic fir_word_t filter_sample(input logic signed [fir_pkg::DATA_W-1:0] x);
        int        taps;
        longint    acc;
        longint    y;
        fir_word_t r;
        sample_hist[hist_head] = x;
        taps = int'(tap_setting);
        if (taps < 1)
            taps = 1;
        if (taps > MAX_TAPS)
            taps = MAX_TAPS;
        acc = 0;
        for (int k = 0; k < taps; k++)
        begin
            acc += longint'(coef_mem[k])
                 * longint'(sample_hist[(hist_head + MAX_TAPS - k) % MAX_TAPS]);
        end
        hist_head = (hist_head + 1) % MAX_TAPS;
        y = (acc + ROUND_HALF) >>> fir_pkg::FRAC_W;
        r.sat = 1'b0;
        if (y > SAMPLE_MAX)
        begin
            y = SAMPLE_MAX;
            r.sat = 1'b1;
        end
        else if (y < SAMPLE_MIN)
        begin
            y = SAMPLE_MIN;
            r.sat = 1'b1;
        end
        r.sample = y[fir_pkg::DATA_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        fir_word_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                sample_hist[i] = '0;
                coef_mem[i]    = '0;
            end
            hist_head   = 0;
            tap_setting = fir_pkg::TAP_CNT_RESET;
            expected_words.delete();
            errs = 0;
            pending_words  <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                tap_setting = cfg_wr_data;
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("sample_out: no word expected, got %0d", sample_out);
                    errs++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (sample_out !== want.sample)
                    begin
                        $error("sample_out: expected %0d, got %0d", want.sample, sample_out);
                        errs++;
                    end
                    if (saturated !== want.sat)
                    begin
                        $error("saturated: expected %0b, got %0b", want.sat, saturated);
                        errs++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (operation == fir_pkg::OP_LOAD)
                begin
                    if (int'(coef_index) < MAX_TAPS)
                        coef_mem[coef_index] = coef_value;
                end
                else
                    expected_words.push_back(filter_sample(sample_in));
            end
            pending_words  <= expected_words.size();
            mismatch_count <= errs;
        end
    end

endmodule

// ----- bench/tb_fir_filter_stream_unit.sv -----
// top of the fir filter bench: clock, reset, random cfg, input words and output stalls
// depends on fir_pkg, fir_filter_stream_unit and fir_stream_checker
module tb_fir_filter_stream_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int MAX_TAPS       = fir_pkg::DEFAULT_MAX_TAPS;
    localparam int SETTLE_CYCLES  = MAX_TAPS + 16;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WORD_TARGET    = 1850;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    logic                                  clk         = 1'b0;
    logic                                  rst_n       = 1'b0;
    logic                                  cfg_wr_en   = 1'b0;
    logic        [fir_pkg::TAP_CNT_W-1:0]  cfg_wr_data = '0;
    logic                                  in_valid    = 1'b0;
    logic                                  in_ready;
    logic                                  operation   = fir_pkg::OP_FILTER;
    logic signed [fir_pkg::DATA_W-1:0]     sample_in   = '0;
    logic        [fir_pkg::COEF_IDX_W-1:0] coef_index  = '0;
    logic signed [fir_pkg::DATA_W-1:0]     coef_value  = '0;
    logic                                  out_valid;
    logic                                  out_ready   = 1'b0;
    logic signed [fir_pkg::DATA_W-1:0]     sample_out;
    logic                                  saturated;

    int mismatch_count;
    int pending_words;
    int words_sent  = 0;
    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    bit rx_hold_req = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    fir_filter_stream_unit #(
        .MAX_TAPS(MAX_TAPS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .sample_in  (sample_in),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .saturated  (saturated)
    );

    fir_stream_checker #(
        .MAX_TAPS(MAX_TAPS)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .sample_in     (sample_in),
        .coef_index    (coef_index),
        .coef_value    (coef_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample_out    (sample_out),
        .saturated     (saturated),
        .mismatch_count(mismatch_count),
        .pending_words (pending_words)
    );

    task automatic push_word(input logic op, input logic signed [fir_pkg::DATA_W-1:0] smp,
                             input logic [fir_pkg::COEF_IDX_W-1:0] idx,
                             input logic signed [fir_pkg::DATA_W-1:0] cv);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        sample_in  <= smp;
        coef_index <= idx;
        coef_value <= cv;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    function automatic logic signed [fir_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return '0;
            3: return fir_pkg::DATA_W'(int'($urandom_range(0, 511)) - 256);
            default: return fir_pkg::DATA_W'($urandom);
        endcase
    endfunction

    function automatic int pick_taps();
        int extremes [7] = '{0, 1, 2, 63, 64, 65, 127};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 8);
            6, 7: return extremes[$urandom_range(0, 6)];
            default: return $urandom_range(0, 127);
        endcase
    endfunction

    task automatic push_random_word(input int taps);
        logic                          op;
        logic [fir_pkg::COEF_IDX_W-1:0] idx;
        int                            span;
        span = (taps < 1) ? 1 : ((taps > MAX_TAPS) ? MAX_TAPS : taps);
        op   = ($urandom_range(0, 4) == 0) ? fir_pkg::OP_LOAD : fir_pkg::OP_FILTER;
        if ($urandom_range(0, 1) == 0)
            idx = fir_pkg::COEF_IDX_W'($urandom_range(0, span - 1));
        else
            idx = fir_pkg::COEF_IDX_W'($urandom_range(0, MAX_TAPS - 1));
        push_word(op, pick_value(), idx, pick_value());
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_words != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_taps(input int n);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= fir_pkg::TAP_CNT_W'(n);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin : sink
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            stall = rx_idle_on ? $urandom_range(0, 15) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        repeat (TIMEOUT_CYCLES) #(CLK_PERIOD);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : source
        int phase;
        int phase_taps;
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // zero coefficients after reset give zero
        push_word(fir_pkg::OP_FILTER, 16'sh7fff, '0, '0);
        push_word(fir_pkg::OP_LOAD, '0, 6'd0, 16'sh8000);
        push_word(fir_pkg::OP_LOAD, '0, 6'd1, 16'sh8000);
        push_word(fir_pkg::OP_LOAD, '0, 6'd63, 16'sh7fff);
        // positive clip, then negative clip
        push_word(fir_pkg::OP_FILTER, 16'sh8000, '0, '0);
        push_word(fir_pkg::OP_FILTER, 16'sh8000, '0, '0);
        push_word(fir_pkg::OP_FILTER, 16'sh7fff, '0, '0);
        push_word(fir_pkg::OP_FILTER, 16'sh7fff, '0, '0);
        // zero taps acts as one tap
        set_taps(0);
        push_word(fir_pkg::OP_FILTER, 16'sh0001, '0, '0);
        push_word(fir_pkg::OP_FILTER, 16'sh8000, '0, '0);
        // tap count above the store is clamped
        set_taps(127);
        push_word(fir_pkg::OP_FILTER, 16'sh4000, '0, '0);
        push_word(fir_pkg::OP_FILTER, 16'shc000, '0, '0);
        // rounding ties go up
        set_taps(1);
        push_word(fir_pkg::OP_LOAD, '0, 6'd0, 16'sh0001);
        push_word(fir_pkg::OP_FILTER, 16'sh4000, '0, '0);
        push_word(fir_pkg::OP_FILTER, 16'shc000, '0, '0);
        push_word(fir_pkg::OP_FILTER, 16'shbfff, '0, '0);
        push_word(fir_pkg::OP_FILTER, 16'sh3fff, '0, '0);

        phase = 0;
        while (words_sent < WORD_TARGET)
        begin
            phase_taps = pick_taps();
            set_taps(phase_taps);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if (phase == 5)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (phase == 2 || phase == 11)
            begin
                rx_hold_req = 1'b1;
                tx_idle_on  = 1'b0;
            end
            n = $urandom_range(40, 110);
            repeat (n) push_random_word(phase_taps);
            phase++;
        end
        settle();

        if (mismatch_count == 0 && pending_words == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
